/* hdl/tpsq_pkg.sv */
// Package for the trimming priority switch queue.
// Holds the outcome codes, FIFO selects, register indexes and reset values.
// No dependencies; the interface, controller and top-level files use it.
package tpsq_pkg;

   // Defaults for the top-level parameters.
   localparam int DEFAULT_FIFO_DEPTH = 64;
   localparam int DEFAULT_TAG_BITS   = 16;

   // Fixed field widths.
   localparam int OUTCOME_W  = 4;
   localparam int TRIM_W     = 32;
   localparam int CAPACITY_W = 7;
   localparam int PERIOD_W   = 8;
   localparam int CSR_DATA_W = 8;
   localparam int CSR_INDEX_W = 1;

   // Configuration register indexes and reset values.
   localparam logic [CSR_INDEX_W-1:0] CSR_DATA_CAPACITY = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ARB_PERIOD    = 1'd1;
   localparam logic [CAPACITY_W-1:0]  CAPACITY_RESET    = 7'd64;
   localparam logic [PERIOD_W-1:0]    PERIOD_RESET      = 8'd10;

   // Result outcome codes.
   localparam logic [OUTCOME_W-1:0] OUT_PUSH_CTRL   = 4'd0;
   localparam logic [OUTCOME_W-1:0] OUT_PUSH_HDR    = 4'd1;
   localparam logic [OUTCOME_W-1:0] OUT_PUSH_TRIM   = 4'd2;
   localparam logic [OUTCOME_W-1:0] OUT_PUSH_DATA   = 4'd3;
   localparam logic [OUTCOME_W-1:0] OUT_DROP_FULL   = 4'd4;
   localparam logic [OUTCOME_W-1:0] OUT_POP_CTRL    = 4'd5;
   localparam logic [OUTCOME_W-1:0] OUT_POP_HDR     = 4'd6;
   localparam logic [OUTCOME_W-1:0] OUT_POP_DATA    = 4'd7;
   localparam logic [OUTCOME_W-1:0] OUT_POP_EMPTY   = 4'd8;

   // FIFO numbering, and the source codes of a popped beat.
   localparam int NUM_FIFOS = 3;
   localparam int FIFO_CTRL = 0;
   localparam int FIFO_HDR  = 1;
   localparam int FIFO_DATA = 2;

   localparam logic [1:0] SRC_NONE = 2'd0;
   localparam logic [1:0] SRC_CTRL = 2'd1;
   localparam logic [1:0] SRC_HDR  = 2'd2;
   localparam logic [1:0] SRC_DATA = 2'd3;

   // Operation codes.
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // Result of one decision, handed from the controller to the output stage.
   typedef struct packed {
      logic [OUTCOME_W-1:0] outcome;
      logic [1:0]           source;
      logic [TRIM_W-1:0]    trim_total;
      logic                 all_empty;
   } decision_type;

endpackage

/* hdl/tpsq_if.sv */
// Channel interfaces of the trimming priority switch queue.
// Request and response channels with valid/ready handshake; uses tpsq_pkg.
interface tpsq_req_if #(parameter int TAG_BITS = tpsq_pkg::DEFAULT_TAG_BITS);
   logic                valid;
   logic                ready;
   logic                operation;
   logic [TAG_BITS-1:0] packet_tag;
   logic                ack_flag;
   logic                syn_flag;
   logic                nack_flag;
   logic                header_flag;
   logic                pull_flag;

   modport source (output valid, operation, packet_tag, ack_flag, syn_flag, nack_flag,
                   header_flag, pull_flag, input ready);
   modport sink (input valid, operation, packet_tag, ack_flag, syn_flag, nack_flag,
                 header_flag, pull_flag, output ready);
endinterface

interface tpsq_rsp_if #(parameter int TAG_BITS = tpsq_pkg::DEFAULT_TAG_BITS);
   logic                valid;
   logic                ready;
   logic [3:0]          outcome;
   logic [TAG_BITS-1:0] out_tag;
   logic                out_trimmed;
   logic [31:0]         trim_total;
   logic                all_empty;

   modport source (output valid, outcome, out_tag, out_trimmed, trim_total, all_empty,
                   input ready);
   modport sink (input valid, outcome, out_tag, out_trimmed, trim_total, all_empty,
                 output ready);
endinterface

/* hdl/tpsq_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Used for the three tag FIFO stores; no dependencies.
module tpsq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/tpsq_ctrl.sv */
// Queue controller: FIFO pointers and counts, push/pop decision, arbitration
// phase and trim counter. Drives the RAM write and read addresses; uses tpsq_pkg.
module tpsq_ctrl #(
   parameter int FIFO_DEPTH = tpsq_pkg::DEFAULT_FIFO_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic                                operation,
   input  logic                                is_ctrl,
   input  logic                                is_hdr,
   input  logic [tpsq_pkg::CAPACITY_W-1:0]     data_capacity,
   input  logic [tpsq_pkg::PERIOD_W-1:0]       arbitration_period,
   output logic [tpsq_pkg::NUM_FIFOS-1:0]      wr_en,
   output logic [$clog2(FIFO_DEPTH)-1:0]       wr_addr [tpsq_pkg::NUM_FIFOS],
   output logic [$clog2(FIFO_DEPTH)-1:0]       rd_addr [tpsq_pkg::NUM_FIFOS],
   output logic                                trim_mark,
   output tpsq_pkg::decision_type              decision
);
   import tpsq_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam int CMP_W = (CNT_W > CAPACITY_W) ? CNT_W : CAPACITY_W;
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(FIFO_DEPTH);

   logic [PTR_W-1:0]    rd_ptr_ff [NUM_FIFOS];
   logic [PTR_W-1:0]    rd_ptr_in [NUM_FIFOS];
   logic [PTR_W-1:0]    wr_ptr_ff [NUM_FIFOS];
   logic [PTR_W-1:0]    wr_ptr_in [NUM_FIFOS];
   logic [CNT_W-1:0]    count_ff  [NUM_FIFOS];
   logic [CNT_W-1:0]    count_in  [NUM_FIFOS];
   logic [PERIOD_W-1:0] phase_ff;
   logic [PERIOD_W-1:0] phase_in;
   logic [TRIM_W-1:0]   trim_ff;
   logic [TRIM_W-1:0]   trim_in;

   logic [NUM_FIFOS-1:0] put;
   logic [NUM_FIFOS-1:0] take;
   logic [NUM_FIFOS-1:0] full;
   logic                 over_capacity;
   logic [PERIOD_W:0]    phase_sum;
   logic [OUTCOME_W-1:0] outcome;
   logic [1:0]           source;

   // Full flags and the trim threshold on the data FIFO.
   always_comb begin
      for (int i = 0; i < NUM_FIFOS; i++) begin
         full[i] = (count_ff[i] == FULL_CNT);
      end
      over_capacity = (CMP_W'(count_ff[FIFO_DATA]) >= CMP_W'(data_capacity));
   end

   assign phase_sum = {1'b0, phase_ff} + (PERIOD_W + 1)'(1);

   // Decide where a push goes or which FIFO a pop serves.
   always_comb begin
      put       = '0;
      take      = '0;
      trim_mark = 1'b0;
      outcome   = OUT_POP_EMPTY;
      source    = SRC_NONE;
      phase_in  = phase_ff;
      trim_in   = trim_ff;
      if (operation == OP_PUSH) begin
         priority if (is_ctrl) begin
            put[FIFO_CTRL] = !full[FIFO_CTRL];
            outcome = full[FIFO_CTRL] ? OUT_DROP_FULL : OUT_PUSH_CTRL;
         end else if (is_hdr) begin
            put[FIFO_HDR] = !full[FIFO_HDR];
            outcome = full[FIFO_HDR] ? OUT_DROP_FULL : OUT_PUSH_HDR;
         end else if (over_capacity) begin
            put[FIFO_HDR] = !full[FIFO_HDR];
            trim_mark     = 1'b1;
            outcome = full[FIFO_HDR] ? OUT_DROP_FULL : OUT_PUSH_TRIM;
            if (!full[FIFO_HDR] && trim_ff != '1) begin
               trim_in = trim_ff + TRIM_W'(1);
            end
         end else begin
            put[FIFO_DATA] = !full[FIFO_DATA];
            outcome = full[FIFO_DATA] ? OUT_DROP_FULL : OUT_PUSH_DATA;
         end
      end else begin
         priority if (count_ff[FIFO_CTRL] != '0) begin
            take[FIFO_CTRL] = 1'b1;
            outcome = OUT_POP_CTRL;
            source  = SRC_CTRL;
         end else if (count_ff[FIFO_HDR] == '0 && count_ff[FIFO_DATA] == '0) begin
            outcome = OUT_POP_EMPTY;
         end else if (count_ff[FIFO_HDR] == '0) begin
            take[FIFO_DATA] = 1'b1;
            outcome = OUT_POP_DATA;
            source  = SRC_DATA;
         end else if (count_ff[FIFO_DATA] == '0) begin
            take[FIFO_HDR] = 1'b1;
            outcome = OUT_POP_HDR;
            source  = SRC_HDR;
         end else begin
            // Both contend: phase zero serves data, other phases serve headers.
            if (phase_ff == '0) begin
               take[FIFO_DATA] = 1'b1;
               outcome = OUT_POP_DATA;
               source  = SRC_DATA;
            end else begin
               take[FIFO_HDR] = 1'b1;
               outcome = OUT_POP_HDR;
               source  = SRC_HDR;
            end
            phase_in = (phase_sum >= {1'b0, arbitration_period}) ? '0
                                                                  : phase_sum[PERIOD_W-1:0];
         end
      end
   end

   // Pointer and count updates for each FIFO.
   always_comb begin
      for (int i = 0; i < NUM_FIFOS; i++) begin
         wr_ptr_in[i] = wr_ptr_ff[i];
         rd_ptr_in[i] = rd_ptr_ff[i];
         count_in[i]  = count_ff[i];
         if (put[i]) begin
            wr_ptr_in[i] = (wr_ptr_ff[i] == LAST_SLOT) ? '0 : wr_ptr_ff[i] + PTR_W'(1);
            count_in[i]  = count_ff[i] + CNT_W'(1);
         end else if (take[i]) begin
            rd_ptr_in[i] = (rd_ptr_ff[i] == LAST_SLOT) ? '0 : rd_ptr_ff[i] + PTR_W'(1);
            count_in[i]  = count_ff[i] - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_FIFOS; i++) begin
            wr_ptr_ff[i] <= '0;
            rd_ptr_ff[i] <= '0;
            count_ff[i]  <= '0;
         end
         phase_ff <= '0;
         trim_ff  <= '0;
      end else if (accept) begin
         for (int i = 0; i < NUM_FIFOS; i++) begin
            wr_ptr_ff[i] <= wr_ptr_in[i];
            rd_ptr_ff[i] <= rd_ptr_in[i];
            count_ff[i]  <= count_in[i];
         end
         phase_ff <= phase_in;
         trim_ff  <= trim_in;
      end
   end

   // RAM controls: reads always address the head of each FIFO.
   always_comb begin
      for (int i = 0; i < NUM_FIFOS; i++) begin
         wr_en[i]   = accept && put[i];
         wr_addr[i] = wr_ptr_ff[i];
         rd_addr[i] = rd_ptr_ff[i];
      end
   end

   assign decision.outcome    = outcome;
   assign decision.source     = source;
   assign decision.trim_total = trim_in;
   assign decision.all_empty  = (count_in[FIFO_CTRL] == '0) && (count_in[FIFO_HDR] == '0)
                                && (count_in[FIFO_DATA] == '0);

endmodule

/* hdl/trimming_priority_switch_queue.sv */
// Trimming priority switch queue: a switch port's output queue of packet tags
// held in three FIFO RAMs (control, header, data). Every request beat, push or
// pop, produces exactly one response beat: the accepting cycle decides and
// updates pointers, then the read state waits for the FIFO RAM's registered
// read. No new request is taken before the current one reaches the response
// register; a waiting response beat stalls the next acceptance only until
// it is taken. Data pushes beyond data_capacity are stored in the header FIFO
// as trimmed; contended pops serve data once per arbitration_period. Registers
// are to be written through the csr_ port only while the queue is idle; the
// block itself does not enforce this. There is no clearing pass after reset.
module trimming_priority_switch_queue #(
   parameter int FIFO_DEPTH = tpsq_pkg::DEFAULT_FIFO_DEPTH,
   parameter int TAG_BITS   = tpsq_pkg::DEFAULT_TAG_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   tpsq_req_if.sink                            req_bus,
   tpsq_rsp_if.source                          rsp_bus,
   input  logic                                csr_write_enable,
   input  logic [tpsq_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tpsq_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import tpsq_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_READ = 1'b1;

   logic                  state_ff;
   logic                  state_in;
   logic [CAPACITY_W-1:0] capacity_ff;
   logic [PERIOD_W-1:0]   period_ff;
   decision_type          pend_ff;
   decision_type          decision;

   logic                  rsp_valid_ff;
   logic [OUTCOME_W-1:0]  rsp_outcome_ff;
   logic [TAG_BITS-1:0]   rsp_tag_ff;
   logic                  rsp_trimmed_ff;
   logic [TRIM_W-1:0]     rsp_trim_ff;
   logic                  rsp_empty_ff;

   logic                  accept;
   logic [NUM_FIFOS-1:0]  wr_en;
   logic [PTR_W-1:0]      wr_addr [NUM_FIFOS];
   logic [PTR_W-1:0]      rd_addr [NUM_FIFOS];
   logic                  trim_mark;
   logic [TAG_BITS-1:0]   ctrl_rd_data;
   logic [TAG_BITS:0]     hdr_rd_data;
   logic [TAG_BITS-1:0]   data_rd_data;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
         period_ff   <= PERIOD_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DATA_CAPACITY: capacity_ff <= csr_write_data[CAPACITY_W-1:0];
            CSR_ARB_PERIOD:    period_ff   <= csr_write_data[PERIOD_W-1:0];
            default:           ;
         endcase
      end
   end

   // Take a request beat when idle and the response register is free or draining.
   assign req_bus.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign accept        = req_bus.valid && req_bus.ready;

   tpsq_ctrl #(.FIFO_DEPTH(FIFO_DEPTH)) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .accept             (accept),
      .operation          (req_bus.operation),
      .is_ctrl            (req_bus.ack_flag | req_bus.syn_flag | req_bus.nack_flag),
      .is_hdr             (req_bus.header_flag | req_bus.pull_flag),
      .data_capacity      (capacity_ff),
      .arbitration_period (period_ff),
      .wr_en              (wr_en),
      .wr_addr            (wr_addr),
      .rd_addr            (rd_addr),
      .trim_mark          (trim_mark),
      .decision           (decision)
   );

   // FIFO stores; the header store carries the trimmed mark above the tag.
   tpsq_ram #(.WIDTH(TAG_BITS), .DEPTH(FIFO_DEPTH)) u_ctrl_ram (
      .clock   (clock),
      .wr_en   (wr_en[FIFO_CTRL]),
      .wr_addr (wr_addr[FIFO_CTRL]),
      .wr_data (req_bus.packet_tag),
      .rd_addr (rd_addr[FIFO_CTRL]),
      .rd_data (ctrl_rd_data)
   );

   tpsq_ram #(.WIDTH(TAG_BITS + 1), .DEPTH(FIFO_DEPTH)) u_hdr_ram (
      .clock   (clock),
      .wr_en   (wr_en[FIFO_HDR]),
      .wr_addr (wr_addr[FIFO_HDR]),
      .wr_data ({trim_mark, req_bus.packet_tag}),
      .rd_addr (rd_addr[FIFO_HDR]),
      .rd_data (hdr_rd_data)
   );

   tpsq_ram #(.WIDTH(TAG_BITS), .DEPTH(FIFO_DEPTH)) u_data_ram (
      .clock   (clock),
      .wr_en   (wr_en[FIFO_DATA]),
      .wr_addr (wr_addr[FIFO_DATA]),
      .wr_data (req_bus.packet_tag),
      .rd_addr (rd_addr[FIFO_DATA]),
      .rd_data (data_rd_data)
   );

   // Sequencer: an idle state that decides on accept, then a read state for the RAM read.
   always_comb begin
      unique case (state_ff)
         ST_IDLE: state_in = accept ? ST_READ : ST_IDLE;
         ST_READ: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Hold the decision until the read data is back.
   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= decision;
      end
   end

   // Response register: loaded in the read cycle, where it is always empty.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_READ) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         rsp_outcome_ff <= pend_ff.outcome;
         rsp_trim_ff    <= pend_ff.trim_total;
         rsp_empty_ff   <= pend_ff.all_empty;
         unique case (pend_ff.source)
            SRC_CTRL: begin
               rsp_tag_ff     <= ctrl_rd_data;
               rsp_trimmed_ff <= 1'b0;
            end
            SRC_HDR: begin
               rsp_tag_ff     <= hdr_rd_data[TAG_BITS-1:0];
               rsp_trimmed_ff <= hdr_rd_data[TAG_BITS];
            end
            SRC_DATA: begin
               rsp_tag_ff     <= data_rd_data;
               rsp_trimmed_ff <= 1'b0;
            end
            default: begin
               rsp_tag_ff     <= '0;
               rsp_trimmed_ff <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.outcome     = rsp_outcome_ff;
   assign rsp_bus.out_tag     = rsp_tag_ff;
   assign rsp_bus.out_trimmed = rsp_trimmed_ff;
   assign rsp_bus.trim_total  = rsp_trim_ff;
   assign rsp_bus.all_empty   = rsp_empty_ff;

endmodule
